[hdl/twc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twc_pkg
// Shared widths, constants and handshake structs of the textured wall column
// generator.
// ----------------------------------------------------------------------------
package twc_pkg;

  // screen geometry
  localparam int SCREEN_HEIGHT = 64;
  localparam int HALF_SCREEN   = SCREEN_HEIGHT / 2;
  localparam int LOW_HALF      = SCREEN_HEIGHT - HALF_SCREEN;
  localparam int ROW_W         = $clog2(SCREEN_HEIGHT);
  localparam int ROW_OUT_W     = 6;

  // configuration port
  localparam int NUM_REGS   = 8;
  localparam int NUM_TEX    = NUM_REGS / 2;
  localparam int CFG_IDX_W  = 4;
  localparam int DIM_W      = 11;
  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(64);

  // item fields
  localparam int COL_W   = 10;
  localparam int DIST_W  = 20;
  localparam int DIR_W   = 16;
  localparam int POS_W   = 20;
  localparam int TEXEL_W = 10;
  localparam int TID_W   = 2;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 40;

  // texture ids
  localparam logic [TID_W-1:0] TEX_NORTH = 2'd0;
  localparam logic [TID_W-1:0] TEX_SOUTH = 2'd1;
  localparam logic [TID_W-1:0] TEX_EAST  = 2'd2;
  localparam logic [TID_W-1:0] TEX_WEST  = 2'd3;

  // arithmetic widths
  localparam int H_W       = 16;
  localparam int HALF_W    = H_W - 1;
  localparam int ACC_W     = 27;
  localparam int ACC_FRAC  = 16;
  localparam int FRAC_W    = 26;
  localparam int POS_SHIFT = 14;
  localparam int POS_LO_W  = FRAC_W - POS_SHIFT;

  // shared divider
  localparam int DVD_W   = 27;
  localparam int DVS_W   = 20;
  localparam int CNT_W   = 5;
  localparam int H_NUM   = SCREEN_HEIGHT * 4096;
  localparam int H_NUM_W = $clog2(H_NUM + 1);
  localparam logic [DVD_W-1:0] H_DIVIDEND  = DVD_W'(H_NUM) << (DVD_W - H_NUM_W);
  localparam logic [CNT_W-1:0] H_STEPS     = CNT_W'(H_NUM_W);
  localparam logic [CNT_W-1:0] STEP_STEPS  = CNT_W'(DVD_W);

  // shared multiplier
  localparam int MUL_A_W = 28;
  localparam int MUL_B_W = 21;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
    logic [CNT_W-1:0]  steps;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DVD_W-1:0]  quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

[hdl/twc_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twc_div
// Restoring divider, one quotient bit per cycle, left-aligned dividend.
// ----------------------------------------------------------------------------
module twc_div
  import twc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic             active_q, active_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W-1:0] rem_q;
  logic [DVD_W-1:0] dvd_q;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] dvs_q;

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    if (req_i.start) begin
      active_d = 1'b1;
      cnt_d    = req_i.steps;
    end else if (active_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      quo_q <= '0;
    end else if (active_q) begin
      rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
`default_nettype wire

[hdl/twc_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twc_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module twc_mul
  import twc_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic signed [MUL_A_W-1:0]  a_i,
  input  wire logic signed [MUL_B_W-1:0]  b_i,
  output logic signed [MUL_P_W-1:0]       p_o
);

  logic signed [MUL_P_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
  end

  assign p_o = prod_q;

endmodule
`default_nettype wire

[hdl/textured_wall_column_generator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// textured_wall_column_generator
// Turns one column's ray hit into a run of texel coordinates, one per row.
// sequence after accept: the slice height divide, the wall multiply and texel
//   column, the row step divide and the start offset multiply; then one row per
//   cycle while tready is high
// columns do not overlap: a new hit is accepted only once the sequencer is back
//   in idle after the last row of the previous column
// reset: async active low; texture sizes return to 64, sequencer to idle
// ----------------------------------------------------------------------------
module textured_wall_column_generator
  import twc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // config
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [DIM_W-1:0]      cfg_data_i,
  // ray hit in
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // column[9:0], perp_dist[29:10], dir_x[45:30], dir_y[61:46],
  // pos_x[81:62], pos_y[101:82], zero pad[103:102]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // hit_side[0]
  input  wire logic                  s_axis_tuser,
  // texel out
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // out_column[9:0], row[15:10], texel_x[25:16], texel_y[35:26], zero pad[39:36]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // texture_id[1:0]
  output logic [TID_W-1:0]           m_axis_tuser,
  output logic                       m_axis_tlast
);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_DIVH = 10'b00_0000_0010,
    ST_MULW = 10'b00_0000_0100,
    ST_FRAC = 10'b00_0000_1000,
    ST_MULX = 10'b00_0001_0000,
    ST_TEXX = 10'b00_0010_0000,
    ST_DIVS = 10'b00_0100_0000,
    ST_MULA = 10'b00_1000_0000,
    ST_ACCM = 10'b01_0000_0000,
    ST_EMIT = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // texture size registers
  logic [DIM_W-1:0] tex_w_q [NUM_TEX];
  logic [DIM_W-1:0] tex_h_q [NUM_TEX];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TEX; i++) begin
        tex_w_q[i] <= DIM_RESET;
        tex_h_q[i] <= DIM_RESET;
      end
    end else if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(NUM_REGS))) begin
      if (cfg_idx_i[0]) begin
        tex_h_q[cfg_idx_i[TID_W:1]] <= cfg_data_i;
      end else begin
        tex_w_q[cfg_idx_i[TID_W:1]] <= cfg_data_i;
      end
    end
  end

  // input unpack
  logic [COL_W-1:0]         in_col;
  logic [DIST_W-1:0]        in_perp;
  logic signed [DIR_W-1:0]  in_dx, in_dy;
  logic [POS_W-1:0]         in_px, in_py;
  logic                     in_side;
  logic [TID_W-1:0]         in_tid;

  assign in_col  = s_axis_tdata[9:0];
  assign in_perp = s_axis_tdata[29:10];
  assign in_dx   = s_axis_tdata[45:30];
  assign in_dy   = s_axis_tdata[61:46];
  assign in_px   = s_axis_tdata[81:62];
  assign in_py   = s_axis_tdata[101:82];
  assign in_side = s_axis_tuser;

  always_comb begin
    if (in_side) begin
      in_tid = in_dy[DIR_W-1] ? TEX_SOUTH : TEX_NORTH;
    end else begin
      in_tid = in_dx[DIR_W-1] ? TEX_EAST : TEX_WEST;
    end
  end

  logic in_hs, out_hs;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_hs         = s_axis_tvalid && s_axis_tready;

  // per-column registers
  logic [COL_W-1:0]        col_q;
  logic [DIST_W-1:0]       perp_q;
  logic signed [DIR_W-1:0] dir_q;
  logic [POS_LO_W-1:0]     pos_q;
  logic [TID_W-1:0]        tid_q;
  logic [DIM_W-1:0]        wid_q;
  logic [DIM_W-1:0]        theight_q;
  logic [H_W-1:0]          h_q;
  logic [FRAC_W-1:0]       frac_q;
  logic [TEXEL_W-1:0]      tx_q;
  logic [ACC_W-1:0]        step_q;
  logic [ACC_W-1:0]        accum_q;
  logic [ROW_W-1:0]        cur_row_q;
  logic [ROW_W-1:0]        end_row_q;

  // shared units
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  twc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  twc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // slice height, saturated
  logic [H_W-1:0] h_sat;
  assign h_sat = (|div_rsp.quotient[DVD_W-1:H_W]) ? '1 : div_rsp.quotient[H_W-1:0];

  always_comb begin
    div_req.start = (in_hs) || ((state_q == ST_DIVH) && div_rsp.done);
    if (state_q == ST_IDLE) begin
      div_req.dividend = H_DIVIDEND;
      div_req.divisor  = in_perp;
      div_req.steps    = H_STEPS;
    end else begin
      div_req.dividend = {theight_q, {ACC_FRAC{1'b0}}};
      div_req.divisor  = {{(DVS_W-H_W){1'b0}}, h_q};
      div_req.steps    = STEP_STEPS;
    end
    // dividing by the fresh slice height before it lands in h_q
    if (state_q == ST_DIVH) begin
      div_req.divisor = {{(DVS_W-H_W){1'b0}}, h_sat};
    end
  end

  // row span from the slice height
  logic [HALF_W-1:0] half_h;
  logic [HALF_W-1:0] row_ofs;
  logic [ROW_W-1:0]  start_row;
  logic [ROW_W-1:0]  stop_row;

  assign half_h    = h_q[H_W-1:1];
  assign start_row = (half_h >= HALF_W'(HALF_SCREEN)) ? '0
                   : ROW_W'(HALF_SCREEN) - half_h[ROW_W-1:0];
  assign stop_row  = (half_h >= HALF_W'(LOW_HALF)) ? ROW_W'(SCREEN_HEIGHT - 1)
                   : half_h[ROW_W-1:0] + ROW_W'(HALF_SCREEN);
  assign row_ofs   = (half_h > HALF_W'(HALF_SCREEN)) ? half_h - HALF_W'(HALF_SCREEN)
                   : '0;

  always_comb begin
    case (state_q)
      ST_MULW: begin
        mul_a = $signed({{(MUL_A_W-DIST_W){1'b0}}, perp_q});
        mul_b = MUL_B_W'(dir_q);
      end
      ST_MULX: begin
        mul_a = $signed({{(MUL_A_W-FRAC_W){1'b0}}, frac_q});
        mul_b = $signed({{(MUL_B_W-DIM_W){1'b0}}, wid_q});
      end
      default: begin
        mul_a = $signed({{(MUL_A_W-ACC_W){1'b0}}, step_q});
        mul_b = $signed({{(MUL_B_W-HALF_W){1'b0}}, row_ofs});
      end
    endcase
  end

  // wall hit fraction and texel column
  logic [FRAC_W-1:0] wall_frac;
  logic [DIM_W-1:0]  tx_raw;
  assign wall_frac = mul_p[FRAC_W-1:0] + {pos_q, {POS_SHIFT{1'b0}}};
  assign tx_raw    = mul_p[FRAC_W+DIM_W-1:FRAC_W];

  // texel row, clamped to the texture
  logic [DIM_W-1:0]   ty_raw;
  logic [DIM_W-1:0]   h_m1;
  logic [DIM_W-1:0]   ty_clip;
  logic [TEXEL_W-1:0] texel_y;
  logic [ROW_W-1:0]   next_row;
  logic               is_last;

  assign ty_raw   = accum_q[ACC_W-1:ACC_FRAC];
  assign h_m1     = theight_q - 1'b1;
  assign next_row = cur_row_q + 1'b1;
  assign is_last  = (next_row == end_row_q);

  always_comb begin
    if (theight_q == '0) begin
      ty_clip = '0;
    end else if (ty_raw > h_m1) begin
      ty_clip = h_m1;
    end else begin
      ty_clip = ty_raw;
    end
  end
  assign texel_y = ty_clip[DIM_W-1] ? '1 : ty_clip[TEXEL_W-1:0];

  assign m_axis_tvalid = (state_q == ST_EMIT);
  assign out_hs        = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = {4'b0, texel_y, tx_q, ROW_OUT_W'(cur_row_q), col_q};
  assign m_axis_tuser  = tid_q;
  assign m_axis_tlast  = is_last;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_hs) state_d = ST_DIVH;
      ST_DIVH: if (div_rsp.done) state_d = ST_MULW;
      ST_MULW: state_d = ST_FRAC;
      ST_FRAC: state_d = ST_MULX;
      ST_MULX: state_d = ST_TEXX;
      ST_TEXX: state_d = ST_DIVS;
      ST_DIVS: if (div_rsp.done) state_d = ST_MULA;
      ST_MULA: state_d = ST_ACCM;
      ST_ACCM: state_d = (start_row < stop_row) ? ST_EMIT : ST_IDLE;
      ST_EMIT: if (out_hs && is_last) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cur_row_q <= '0;
      end_row_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_ACCM) begin
        cur_row_q <= start_row;
        end_row_q <= stop_row;
      end else if (out_hs) begin
        cur_row_q <= next_row;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_hs) begin
      col_q     <= in_col;
      perp_q    <= in_perp;
      dir_q     <= in_side ? in_dx : in_dy;
      pos_q     <= in_side ? in_px[POS_LO_W-1:0] : in_py[POS_LO_W-1:0];
      tid_q     <= in_tid;
      wid_q     <= tex_w_q[in_tid];
      theight_q <= tex_h_q[in_tid];
    end
    if ((state_q == ST_DIVH) && div_rsp.done) begin
      h_q <= h_sat;
    end
    if (state_q == ST_FRAC) begin
      frac_q <= wall_frac;
    end
    if (state_q == ST_TEXX) begin
      tx_q <= tx_raw[DIM_W-1] ? '1 : tx_raw[TEXEL_W-1:0];
    end
    if ((state_q == ST_DIVS) && div_rsp.done) begin
      step_q <= div_rsp.quotient[ACC_W-1:0];
    end
    if (state_q == ST_ACCM) begin
      accum_q <= mul_p[ACC_W-1:0];
    end else if (out_hs) begin
      accum_q <= accum_q + step_q;
    end
  end

  // checks
  a_ready_xor_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a row item is pending");

  a_last_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("sequencer did not return to idle after the last row");

  a_accept_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("still ready after accepting an item");

  a_row_in_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (cur_row_q < end_row_q))
    else $error("emitted row outside the column span");

endmodule
`default_nettype wire
